/* sv/crt_snf_pkg.sv */
// Shared types and constants of the scanline noise filter.
// No dependencies; every other file imports this package.
package crt_snf_pkg;

  localparam int XW     = 9;
  localparam int YW     = 8;
  localparam int CHW    = 8;
  localparam int PIXW   = 32;
  localparam int FRAC_W = 9;
  localparam int DICE_W = 12;
  localparam int SHFT_W = 2;
  localparam int VIG_W  = 6;
  localparam int Q10_W  = 9;

  localparam int FRAC_ONE         = 256;
  localparam int ROLL_STEP        = 20;
  localparam int ROLL_START_LIMIT = 8;
  localparam int NOISE_ZONE       = 20;
  localparam int VIG_X            = 16;
  localparam int VIG_Y            = 32;
  localparam int NOISY_DICE       = 4;

  localparam logic [15:0] GAIN_CALM = 16'd13005;
  localparam logic [15:0] GAIN_ROLL = 16'd39014;

  // floor(d/10) = (d*6554) >> 16 for d < 4096
  localparam int DIV10_MUL = 6554;
  // floor(c*5/6) = (c*54615) >> 16 for c < 256
  localparam int MUL5_DIV6 = 54615;

  localparam int Q_DEPTH = 8;

  typedef enum logic [1:0] {
    KIND_LOAD = 2'd0,
    KIND_EMIT = 2'd1,
    KIND_TICK = 2'd2
  } kind_e;

  // one sampled pixel and its context, front to back
  typedef struct packed {
    logic [XW-1:0]    x;
    logic [YW-1:0]    y;
    logic             even;
    logic             gain_hi;
    logic [VIG_W-1:0] vig;
    logic [CHW-1:0]   red;
    logic [CHW-1:0]   green;
    logic [CHW-1:0]   blue;
    logic [CHW-1:0]   alpha;
    logic [CHW-1:0]   noise_r;
    logic [CHW-1:0]   noise_g;
    logic [CHW-1:0]   noise_b;
  } qent_t;

endpackage

/* sv/crt_snf_front.sv */
// Front end: accepts items, keeps roll state and config, owns the frame store.
// Emits leave as sampled pixels toward the queue. Depends on crt_snf_pkg.
module crt_snf_front #(
  parameter int FRAME_WIDTH  = 320,
  parameter int FRAME_HEIGHT = 240
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push,
  output logic                            full,
  input  logic [1:0]                      kind_i,
  input  logic [crt_snf_pkg::XW-1:0]      x_i,
  input  logic [crt_snf_pkg::YW-1:0]      y_i,
  input  logic [crt_snf_pkg::PIXW-1:0]    pix_i,
  input  logic [crt_snf_pkg::CHW-1:0]     noise_r_i,
  input  logic [crt_snf_pkg::CHW-1:0]     noise_g_i,
  input  logic [crt_snf_pkg::CHW-1:0]     noise_b_i,
  input  logic [crt_snf_pkg::DICE_W-1:0]  dice_i,
  input  logic [crt_snf_pkg::SHFT_W-1:0]  red_shift_i,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [crt_snf_pkg::FRAC_W-1:0]  cfg_data_i,
  input  logic                            take_i,
  output logic                            q_push_o,
  output crt_snf_pkg::qent_t              q_ent_o
);
  import crt_snf_pkg::*;

  localparam int DEPTH = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int SW    = $clog2(FRAME_HEIGHT);
  localparam int RW    = $clog2(FRAME_HEIGHT + ROLL_STEP + 1);
  localparam int PW    = FRAC_W + RW + 2;
  localparam int SUMW  = ((RW > YW) ? RW : YW) + 1;
  localparam int VX_W  = 20;
  localparam int CRW   = $clog2(Q_DEPTH + 1);
  localparam bit ZONE_ON = FRAME_HEIGHT >= NOISE_ZONE;
  localparam int ZONE_LO = ZONE_ON ? FRAME_HEIGHT - NOISE_ZONE : 0;

  // ---------------- accept, config, roll state ----------------
  logic              accept;
  logic              in_range;
  logic              emit_ok;
  logic              load_ok;
  logic              tick;
  logic [FRAC_W-1:0] frac_q;
  logic [FRAC_W-1:0] f_eff;
  logic [RW-1:0]     roll_now_q, roll_prev_q;
  logic              rolling_q;
  logic [RW-1:0]     roll_sum;
  logic              roll_go;
  logic [CRW-1:0]    credit_q;

  assign accept   = push && !full;
  assign in_range = (32'(x_i) < 32'(FRAME_WIDTH)) && (32'(y_i) < 32'(FRAME_HEIGHT));
  assign emit_ok  = accept && (kind_i == KIND_EMIT) && in_range;
  assign load_ok  = accept && (kind_i == KIND_LOAD) && in_range;
  assign tick     = accept && (kind_i == KIND_TICK);
  assign full     = credit_q == CRW'(Q_DEPTH);
  assign cfg_ready = 1'b1;

  assign roll_sum = roll_now_q + RW'(ROLL_STEP);
  assign roll_go  = rolling_q || (dice_i < DICE_W'(ROLL_START_LIMIT));
  assign f_eff    = (frac_q > FRAC_W'(FRAC_ONE)) ? FRAC_W'(FRAC_ONE) : frac_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frac_q      <= FRAC_W'(FRAC_ONE);
      roll_now_q  <= '0;
      roll_prev_q <= '0;
      rolling_q   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        frac_q <= cfg_data_i;
      end
      if (tick) begin
        if (!roll_go) begin
          roll_prev_q <= roll_now_q;
        end else if (roll_sum > RW'(FRAME_HEIGHT)) begin
          roll_now_q  <= '0;
          roll_prev_q <= '0;
          rolling_q   <= 1'b0;
        end else begin
          roll_prev_q <= roll_now_q;
          roll_now_q  <= roll_sum;
          rolling_q   <= 1'b1;
        end
      end
    end
  end

  // emits held in the pipeline or the queue
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      credit_q <= '0;
    end else if (emit_ok && !take_i) begin
      credit_q <= credit_q + CRW'(1);
    end else if (!emit_ok && take_i) begin
      credit_q <= credit_q - CRW'(1);
    end
  end

  // ---------------- stage 1: interpolation product, dice / 10 ----------------
  logic signed [RW:0]   diff;
  logic signed [PW-1:0] prod_d;
  logic [25:0]          div10;

  assign diff   = $signed({1'b0, roll_now_q}) - $signed({1'b0, roll_prev_q});
  assign prod_d = PW'($signed({1'b0, f_eff})) * PW'(diff);
  assign div10  = 26'(dice_i) * 26'(DIV10_MUL);

  logic                 p1_vld_q, p1_load_q, p1_rolling_q;
  logic [XW-1:0]        p1_x_q;
  logic [YW-1:0]        p1_y_q;
  logic [PIXW-1:0]      p1_pix_q;
  logic [CHW-1:0]       p1_nr_q, p1_ng_q, p1_nb_q;
  logic [DICE_W-1:0]    p1_dice_q;
  logic [Q10_W-1:0]     p1_q10_q;
  logic [SHFT_W-1:0]    p1_shift_q;
  logic signed [PW-1:0] p1_prod_q;
  logic [RW-1:0]        p1_prev_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_vld_q <= 1'b0;
    end else begin
      p1_vld_q <= emit_ok || load_ok;
    end
  end

  always_ff @(posedge clk_i) begin
    p1_load_q    <= load_ok;
    p1_x_q       <= x_i;
    p1_y_q       <= y_i;
    p1_pix_q     <= pix_i;
    p1_nr_q      <= noise_r_i;
    p1_ng_q      <= noise_g_i;
    p1_nb_q      <= noise_b_i;
    p1_dice_q    <= dice_i;
    p1_q10_q     <= div10[16 +: Q10_W];
    p1_shift_q   <= red_shift_i;
    p1_prod_q    <= prod_d;
    p1_prev_q    <= roll_prev_q;
    p1_rolling_q <= rolling_q;
  end

  // ---------------- stage 2: sample row, red column, vignette ----------------
  logic signed [PW:0] acc;
  logic [RW-1:0]      roll;
  logic [SUMW-1:0]    srow_sum;
  logic [SUMW-1:0]    srow;
  logic [SW-1:0]      s_d;
  logic [XW:0]        rx_sum;
  logic [XW:0]        rx_d;
  logic [DICE_W-1:0]  dice_rem;
  logic [VX_W-1:0]    twox, twoy, dx, dy, dx16, dy32;
  logic [VIG_W-1:0]   vx, vy;

  // weighted roll is never negative, so the shift truncates like the divide
  assign acc      = (PW+1)'($signed({1'b0, p1_prev_q, 8'b0})) + (PW+1)'(p1_prod_q);
  assign roll     = acc[8 +: RW];
  assign srow_sum = SUMW'(p1_y_q) + SUMW'(roll);
  assign srow     = (srow_sum >= SUMW'(FRAME_HEIGHT)) ? srow_sum - SUMW'(FRAME_HEIGHT)
                                                      : srow_sum;
  assign s_d      = p1_load_q ? SW'(p1_y_q) : SW'(srow);

  assign rx_sum = {1'b0, p1_x_q} + (XW+1)'(p1_shift_q);
  assign rx_d   = (rx_sum > (XW+1)'(FRAME_WIDTH - 1)) ? (XW+1)'(FRAME_WIDTH - 1) : rx_sum;

  assign dice_rem = p1_dice_q - DICE_W'(p1_q10_q) * DICE_W'(10);

  assign twox = VX_W'({p1_x_q, 1'b0});
  assign twoy = VX_W'({p1_y_q, 1'b0});
  assign dx   = (VX_W'(FRAME_WIDTH) > twox) ? VX_W'(FRAME_WIDTH) - twox
                                           : twox - VX_W'(FRAME_WIDTH);
  assign dy   = (VX_W'(FRAME_HEIGHT) > twoy) ? VX_W'(FRAME_HEIGHT) - twoy
                                            : twoy - VX_W'(FRAME_HEIGHT);
  assign dx16 = dx << 4;
  assign dy32 = dy << 5;

  // floor(dx*16/W) and floor(dy*32/H) as counts of thresholds passed
  always_comb begin
    vx = '0;
    for (int k = 1; k <= VIG_X; k++) begin
      vx = vx + VIG_W'(dx16 >= VX_W'(k * FRAME_WIDTH));
    end
    vy = '0;
    for (int k = 1; k <= VIG_Y; k++) begin
      vy = vy + VIG_W'(dy32 >= VX_W'(k * FRAME_HEIGHT));
    end
  end

  logic              p2_vld_q, p2_load_q, p2_even_q, p2_remlo_q, p2_rolling_q;
  logic [SW-1:0]     p2_s_q;
  logic [XW-1:0]     p2_x_q;
  logic [XW:0]       p2_rx_q;
  logic [YW-1:0]     p2_y_q;
  logic [VIG_W-1:0]  p2_vig_q;
  logic [PIXW-1:0]   p2_pix_q;
  logic [CHW-1:0]    p2_nr_q, p2_ng_q, p2_nb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p2_vld_q <= 1'b0;
    end else begin
      p2_vld_q <= p1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p2_load_q    <= p1_load_q;
    p2_s_q       <= s_d;
    p2_x_q       <= p1_x_q;
    p2_rx_q      <= rx_d;
    p2_y_q       <= p1_y_q;
    p2_even_q    <= !p1_y_q[0];
    p2_vig_q     <= vx + vy;
    p2_remlo_q   <= dice_rem < DICE_W'(NOISY_DICE);
    p2_rolling_q <= p1_rolling_q;
    p2_pix_q     <= p1_pix_q;
    p2_nr_q      <= p1_nr_q;
    p2_ng_q      <= p1_ng_q;
    p2_nb_q      <= p1_nb_q;
  end

  // ---------------- stage 3: store addresses, gain select ----------------
  logic [AW-1:0] row_base;
  logic          gain_hi_d;

  assign row_base  = AW'(p2_s_q) * AW'(FRAME_WIDTH);
  assign gain_hi_d = ZONE_ON && p2_rolling_q && p2_remlo_q &&
                     (32'(p2_s_q) > 32'(ZONE_LO));

  logic              p3_vld_q, p3_load_q, p3_even_q, p3_gain_hi_q;
  logic [AW-1:0]     p3_addr_a_q, p3_addr_r_q;
  logic [XW-1:0]     p3_x_q;
  logic [YW-1:0]     p3_y_q;
  logic [VIG_W-1:0]  p3_vig_q;
  logic [PIXW-1:0]   p3_pix_q;
  logic [CHW-1:0]    p3_nr_q, p3_ng_q, p3_nb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p3_vld_q <= 1'b0;
    end else begin
      p3_vld_q <= p2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p3_load_q    <= p2_load_q;
    p3_addr_a_q  <= row_base + AW'(p2_x_q);
    p3_addr_r_q  <= row_base + AW'(p2_rx_q);
    p3_x_q       <= p2_x_q;
    p3_y_q       <= p2_y_q;
    p3_even_q    <= p2_even_q;
    p3_gain_hi_q <= gain_hi_d;
    p3_vig_q     <= p2_vig_q;
    p3_pix_q     <= p2_pix_q;
    p3_nr_q      <= p2_nr_q;
    p3_ng_q      <= p2_ng_q;
    p3_nb_q      <= p2_nb_q;
  end

  // ---------------- stage 4: frame store, one write and two reads ----------------
  logic [PIXW-1:0] frame_mem [DEPTH];
  logic [PIXW-1:0] rd_a_q, rd_r_q;

  always_ff @(posedge clk_i) begin
    if (p3_vld_q && p3_load_q) begin
      frame_mem[p3_addr_a_q] <= p3_pix_q;
    end
    rd_a_q <= frame_mem[p3_addr_a_q];
    rd_r_q <= frame_mem[p3_addr_r_q];
  end

  logic              p4_vld_q, p4_even_q, p4_gain_hi_q;
  logic [XW-1:0]     p4_x_q;
  logic [YW-1:0]     p4_y_q;
  logic [VIG_W-1:0]  p4_vig_q;
  logic [CHW-1:0]    p4_nr_q, p4_ng_q, p4_nb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p4_vld_q <= 1'b0;
    end else begin
      p4_vld_q <= p3_vld_q && !p3_load_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p4_x_q       <= p3_x_q;
    p4_y_q       <= p3_y_q;
    p4_even_q    <= p3_even_q;
    p4_gain_hi_q <= p3_gain_hi_q;
    p4_vig_q     <= p3_vig_q;
    p4_nr_q      <= p3_nr_q;
    p4_ng_q      <= p3_ng_q;
    p4_nb_q      <= p3_nb_q;
  end

  assign q_push_o        = p4_vld_q;
  assign q_ent_o.x       = p4_x_q;
  assign q_ent_o.y       = p4_y_q;
  assign q_ent_o.even    = p4_even_q;
  assign q_ent_o.gain_hi = p4_gain_hi_q;
  assign q_ent_o.vig     = p4_vig_q;
  assign q_ent_o.red     = rd_r_q[7:0];
  assign q_ent_o.green   = rd_a_q[15:8];
  assign q_ent_o.blue    = rd_a_q[23:16];
  assign q_ent_o.alpha   = rd_a_q[31:24];
  assign q_ent_o.noise_r = p4_nr_q;
  assign q_ent_o.noise_g = p4_ng_q;
  assign q_ent_o.noise_b = p4_nb_q;

`ifndef SYNTHESIS
  a_roll_still: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !rolling_q |-> roll_now_q == roll_prev_q)
    else $error("roll positions differ while not rolling");
  a_roll_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rolling_q |-> roll_now_q == roll_prev_q + RW'(ROLL_STEP))
    else $error("roll positions not one step apart while rolling");
  a_credit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    credit_q <= CRW'(Q_DEPTH))
    else $error("more emits in flight than queue entries");
`endif

endmodule

/* sv/crt_snf_queue.sv */
// Short queue of sampled pixels between front and back.
// Depends on crt_snf_pkg.
module crt_snf_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  crt_snf_pkg::qent_t ent_i,
  input  logic               pop_i,
  output logic               empty_o,
  output crt_snf_pkg::qent_t ent_o
);
  import crt_snf_pkg::*;

  localparam int QAW = $clog2(Q_DEPTH);

  qent_t          slots [Q_DEPTH];
  logic [QAW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QAW:0]   count_q;

  assign empty_o = count_q == '0;
  assign ent_o   = slots[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots[wr_ptr_q] <= ent_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QAW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QAW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + (QAW+1)'(1);
      end else if (!push_i && pop_i) begin
        count_q <= count_q - (QAW+1)'(1);
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && !pop_i && count_q == (QAW+1)'(Q_DEPTH)))
    else $error("item pushed into a full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && empty_o))
    else $error("item popped from an empty queue");
`endif

endmodule

/* sv/crt_snf_back.sv */
// Back end: noise, saturation, scanline darkening and vignette on R, G, B.
// Stalls as one pipeline behind the output register. Depends on crt_snf_pkg.
module crt_snf_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        q_empty_i,
  input  crt_snf_pkg::qent_t          q_ent_i,
  output logic                        take_o,
  output logic                        empty,
  input  logic                        pop,
  output logic [crt_snf_pkg::XW-1:0]  out_x_o,
  output logic [crt_snf_pkg::YW-1:0]  out_y_o,
  output logic [crt_snf_pkg::CHW-1:0] out_red_o,
  output logic [crt_snf_pkg::CHW-1:0] out_green_o,
  output logic [crt_snf_pkg::CHW-1:0] out_blue_o,
  output logic [crt_snf_pkg::CHW-1:0] out_alpha_o
);
  import crt_snf_pkg::*;

  function automatic logic [CHW-1:0] noise_of(input logic [CHW-1:0] n,
                                               input logic [15:0] gain);
    logic [23:0] p;
    p = 24'(n) * 24'(gain);
    return p[23:16];
  endfunction

  function automatic logic [CHW-1:0] sat_add(input logic [CHW-1:0] a,
                                              input logic [CHW-1:0] b);
    logic [CHW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CHW] ? {CHW{1'b1}} : s[CHW-1:0];
  endfunction

  function automatic logic [CHW-1:0] dim(input logic [CHW-1:0] c, input logic even);
    logic [23:0] p;
    p = 24'(c) * 24'(MUL5_DIV6);
    return even ? p[16 +: CHW] : c;
  endfunction

  function automatic logic [CHW-1:0] vig_sub(input logic [CHW-1:0] c,
                                              input logic [VIG_W-1:0] v);
    return (c > CHW'(v)) ? c - CHW'(v) : '0;
  endfunction

  logic        en;
  logic [15:0] gain;

  logic  b1_vld_q, b2_vld_q, b3_vld_q, out_vld_q;
  qent_t b1_q, b2_q, b3_q, out_q;
  qent_t b2_d, b3_d, out_d;
  logic [CHW-1:0] b1_nr_q, b1_ng_q, b1_nb_q;

  assign en     = !out_vld_q || pop;
  assign take_o = en && !q_empty_i;
  assign gain   = q_ent_i.gain_hi ? GAIN_ROLL : GAIN_CALM;
  assign empty  = !out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_vld_q  <= 1'b0;
      b2_vld_q  <= 1'b0;
      b3_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      b1_vld_q  <= take_o;
      b2_vld_q  <= b1_vld_q;
      b3_vld_q  <= b2_vld_q;
      out_vld_q <= b3_vld_q;
    end
  end

  always_comb begin
    b2_d       = b1_q;
    b2_d.red   = sat_add(b1_q.red, b1_nr_q);
    b2_d.green = sat_add(b1_q.green, b1_ng_q);
    b2_d.blue  = sat_add(b1_q.blue, b1_nb_q);

    b3_d       = b2_q;
    b3_d.red   = dim(b2_q.red, b2_q.even);
    b3_d.green = dim(b2_q.green, b2_q.even);
    b3_d.blue  = dim(b2_q.blue, b2_q.even);

    out_d       = b3_q;
    out_d.red   = vig_sub(b3_q.red, b3_q.vig);
    out_d.green = vig_sub(b3_q.green, b3_q.vig);
    out_d.blue  = vig_sub(b3_q.blue, b3_q.vig);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b1_q    <= q_ent_i;
      b1_nr_q <= noise_of(q_ent_i.noise_r, gain);
      b1_ng_q <= noise_of(q_ent_i.noise_g, gain);
      b1_nb_q <= noise_of(q_ent_i.noise_b, gain);
      b2_q    <= b2_d;
      b3_q    <= b3_d;
      out_q   <= out_d;
    end
  end

  assign out_x_o     = out_q.x;
  assign out_y_o     = out_q.y;
  assign out_red_o   = out_q.red;
  assign out_green_o = out_q.green;
  assign out_blue_o  = out_q.blue;
  assign out_alpha_o = out_q.alpha;

endmodule

/* sv/crt_scanline_noise_filter.sv */
// Top level of the CRT scanline noise filter: front end, queue, back end.
// Depends on crt_snf_pkg, crt_snf_front, crt_snf_queue and crt_snf_back.
//
// Usage:
//   Input items enter on push/full: kind 0 loads a source pixel into the
//   frame store, kind 2 advances the vertical roll, kind 1 emits one
//   filtered pixel. Results leave on empty/pop, oldest first; the result
//   ports hold the head item while empty is low.
//   interp_frac is written on cfg_valid/cfg_ready (ready is always high).
//   Throughput: one item per clock while full is low. The front end has
//   four register stages (interpolation multiply, row wrap and vignette,
//   address multiply, frame store read); the back end has four more
//   (noise multiply, saturate, 5/6 scale, vignette subtract). An emit
//   passes both ends and the queue before reaching the result ports.
//   Loads and ticks give no result and never stall the front end.
//   If the receiver stalls, the back end holds; full rises once 8 emits
//   wait in the front end and queue, and drops as soon as one is taken.
//   Reset clears the roll state, sets interp_frac to 256 and empties all
//   stages. The frame store is not cleared: load every pixel before the
//   first emit reads it.
module crt_scanline_noise_filter #(
  parameter int FRAME_WIDTH  = 320,
  parameter int FRAME_HEIGHT = 240
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push,
  output logic                            full,
  input  logic [1:0]                      kind_i,
  input  logic [crt_snf_pkg::XW-1:0]      x_i,
  input  logic [crt_snf_pkg::YW-1:0]      y_i,
  input  logic [crt_snf_pkg::CHW-1:0]     red_i,
  input  logic [crt_snf_pkg::CHW-1:0]     green_i,
  input  logic [crt_snf_pkg::CHW-1:0]     blue_i,
  input  logic [crt_snf_pkg::CHW-1:0]     alpha_i,
  input  logic [crt_snf_pkg::CHW-1:0]     noise_r_i,
  input  logic [crt_snf_pkg::CHW-1:0]     noise_g_i,
  input  logic [crt_snf_pkg::CHW-1:0]     noise_b_i,
  input  logic [crt_snf_pkg::DICE_W-1:0]  dice_i,
  input  logic [crt_snf_pkg::SHFT_W-1:0]  red_shift_i,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [crt_snf_pkg::FRAC_W-1:0]  cfg_data_i,
  output logic                            empty,
  input  logic                            pop,
  output logic [crt_snf_pkg::XW-1:0]      out_x_o,
  output logic [crt_snf_pkg::YW-1:0]      out_y_o,
  output logic [crt_snf_pkg::CHW-1:0]     out_red_o,
  output logic [crt_snf_pkg::CHW-1:0]     out_green_o,
  output logic [crt_snf_pkg::CHW-1:0]     out_blue_o,
  output logic [crt_snf_pkg::CHW-1:0]     out_alpha_o
);
  import crt_snf_pkg::*;

  logic            q_push;
  logic            q_empty;
  logic            take;
  logic [PIXW-1:0] pix;
  qent_t           q_in;
  qent_t           q_out;

  assign pix = {alpha_i, blue_i, green_i, red_i};

  crt_snf_front #(
    .FRAME_WIDTH  (FRAME_WIDTH),
    .FRAME_HEIGHT (FRAME_HEIGHT)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .kind_i      (kind_i),
    .x_i         (x_i),
    .y_i         (y_i),
    .pix_i       (pix),
    .noise_r_i   (noise_r_i),
    .noise_g_i   (noise_g_i),
    .noise_b_i   (noise_b_i),
    .dice_i      (dice_i),
    .red_shift_i (red_shift_i),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data_i  (cfg_data_i),
    .take_i      (take),
    .q_push_o    (q_push),
    .q_ent_o     (q_in)
  );

  crt_snf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .ent_i   (q_in),
    .pop_i   (take),
    .empty_o (q_empty),
    .ent_o   (q_out)
  );

  crt_snf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_ent_i     (q_out),
    .take_o      (take),
    .empty       (empty),
    .pop         (pop),
    .out_x_o     (out_x_o),
    .out_y_o     (out_y_o),
    .out_red_o   (out_red_o),
    .out_green_o (out_green_o),
    .out_blue_o  (out_blue_o),
    .out_alpha_o (out_alpha_o)
  );

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for crt_scanline_noise_filter: a queue-fed driver,
// an output monitor and an in-bench model of the roll, noise and shading.
// Depends on crt_snf_pkg and the crt_scanline_noise_filter RTL.
module tb;
  import crt_snf_pkg::*;

  localparam int FRAME_W      = 320;
  localparam int FRAME_H      = 240;
  localparam int FRAME_PIXELS = FRAME_W * FRAME_H;
  localparam int DRAIN_CYCLES = 16;      // pipeline is 9 deep, loads and ticks trail
  localparam int CYCLE_LIMIT  = 400000;

  localparam logic [1:0] KIND_NONE = 2'd3;

  typedef struct packed {
    logic [CHW-1:0] alpha;
    logic [CHW-1:0] blue;
    logic [CHW-1:0] green;
    logic [CHW-1:0] red;
  } rgba_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [XW-1:0]     x;
    logic [YW-1:0]     y;
    logic [CHW-1:0]    red;
    logic [CHW-1:0]    green;
    logic [CHW-1:0]    blue;
    logic [CHW-1:0]    alpha;
    logic [CHW-1:0]    noise_r;
    logic [CHW-1:0]    noise_g;
    logic [CHW-1:0]    noise_b;
    logic [DICE_W-1:0] dice;
    logic [SHFT_W-1:0] red_shift;
    logic              drain_first;  // hold this item until all pixels are out
  } pix_op_t;

  typedef struct packed {
    logic [XW-1:0]  x;
    logic [YW-1:0]  y;
    logic [CHW-1:0] red;
    logic [CHW-1:0] green;
    logic [CHW-1:0] blue;
    logic [CHW-1:0] alpha;
  } pix_out_t;

  typedef struct {
    int now_row;
    int prev_row;
    bit active;
  } roll_t;

  logic              clk_i      = 1'b0;
  logic              rst_ni     = 1'b0;
  logic              push       = 1'b0;
  logic              full;
  logic              cfg_valid  = 1'b0;
  logic              cfg_ready;
  logic [FRAC_W-1:0] cfg_data_i = '0;
  logic              empty;
  logic              pop        = 1'b0;
  logic [XW-1:0]     out_x_o;
  logic [YW-1:0]     out_y_o;
  logic [CHW-1:0]    out_red_o;
  logic [CHW-1:0]    out_green_o;
  logic [CHW-1:0]    out_blue_o;
  logic [CHW-1:0]    out_alpha_o;

  pix_op_t drv_op = '0;

  // stimulus side: items waiting for the driver and a look-ahead of the roll
  pix_op_t           op_q[$];
  roll_t             gen_roll    = '{0, 0, 1'b0};
  logic [FRAC_W-1:0] gen_frac    = FRAC_W'(FRAC_ONE);
  bit                gen_written [FRAME_PIXELS];
  bit                hold_next   = 1'b0;

  // checking side
  rgba_t             shadow_store [FRAME_PIXELS];
  roll_t             model_roll  = '{0, 0, 1'b0};
  logic [FRAC_W-1:0] model_frac  = FRAC_W'(FRAC_ONE);
  pix_out_t          expected_pixels[$];

  int send_idle_pct  = 0;
  int recv_idle_pct  = 0;
  int emits_sent     = 0;
  int emits_taken    = 0;
  int err_cnt        = 0;
  int items_accepted = 0;
  int hi_gain_cnt    = 0;
  int roll_tick_cnt  = 0;
  int cycle_cnt      = 0;

  crt_scanline_noise_filter dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .kind_i      (drv_op.kind),
    .x_i         (drv_op.x),
    .y_i         (drv_op.y),
    .red_i       (drv_op.red),
    .green_i     (drv_op.green),
    .blue_i      (drv_op.blue),
    .alpha_i     (drv_op.alpha),
    .noise_r_i   (drv_op.noise_r),
    .noise_g_i   (drv_op.noise_g),
    .noise_b_i   (drv_op.noise_b),
    .dice_i      (drv_op.dice),
    .red_shift_i (drv_op.red_shift),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data_i  (cfg_data_i),
    .empty       (empty),
    .pop         (pop),
    .out_x_o     (out_x_o),
    .out_y_o     (out_y_o),
    .out_red_o   (out_red_o),
    .out_green_o (out_green_o),
    .out_blue_o  (out_blue_o),
    .out_alpha_o (out_alpha_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- roll model

  function automatic roll_t advance_roll(roll_t r, logic [DICE_W-1:0] dice);
    roll_t n = r;
    if (dice < ROLL_START_LIMIT) n.active = 1'b1;
    n.prev_row = n.now_row;
    if (n.active) begin
      n.now_row = n.now_row + ROLL_STEP;
      if (n.now_row > FRAME_H) n = '{0, 0, 1'b0};
    end
    return n;
  endfunction

  function automatic int roll_offset(roll_t r, logic [FRAC_W-1:0] frac);
    int w;
    w = (frac > FRAC_ONE) ? FRAC_ONE : int'(frac);
    return (r.prev_row * 256 + w * (r.now_row - r.prev_row)) / 256;
  endfunction

  function automatic int sample_row(roll_t r, logic [FRAC_W-1:0] frac, int row);
    return (row + roll_offset(r, frac)) % FRAME_H;
  endfunction

  function automatic int red_column(int col, int shift);
    return (col + shift > FRAME_W - 1) ? FRAME_W - 1 : col + shift;
  endfunction

  // ---------------------------------------------------------------- pixel model

  function automatic logic [CHW-1:0] shade_channel(int c, int noise, int gain,
                                                   bit even_row, int vig);
    int v;
    v = c + ((noise * gain) >> 16);
    if (v > 255) v = 255;
    if (even_row) v = v * 5 / 6;
    return (v > vig) ? CHW'(v - vig) : '0;
  endfunction

  // Applies one accepted item to the model; returns 1 when it yields a pixel.
  function automatic bit filter_item(input pix_op_t op, output pix_out_t res);
    int    srow, rx, gain, dx, dy, vig;
    bit    even_row;
    rgba_t pix, rpix;
    res = '0;
    case (op.kind)
      KIND_LOAD: begin
        if (op.x < FRAME_W && op.y < FRAME_H)
          shadow_store[op.y * FRAME_W + op.x] =
            '{red: op.red, green: op.green, blue: op.blue, alpha: op.alpha};
        return 1'b0;
      end
      KIND_TICK: begin
        if (model_roll.active || op.dice < ROLL_START_LIMIT) roll_tick_cnt++;
        model_roll = advance_roll(model_roll, op.dice);
        return 1'b0;
      end
      KIND_EMIT: begin
        if (op.x >= FRAME_W || op.y >= FRAME_H) return 1'b0;
        srow = sample_row(model_roll, model_frac, op.y);
        rx   = red_column(op.x, op.red_shift);
        pix  = shadow_store[srow * FRAME_W + op.x];
        rpix = shadow_store[srow * FRAME_W + rx];
        if (model_roll.active && srow > FRAME_H - NOISE_ZONE && op.dice % 10 < NOISY_DICE) begin
          gain = GAIN_ROLL;
          hi_gain_cnt++;
        end else begin
          gain = GAIN_CALM;
        end
        dx = FRAME_W - 2 * int'(op.x);
        if (dx < 0) dx = -dx;
        dy = FRAME_H - 2 * int'(op.y);
        if (dy < 0) dy = -dy;
        vig = dx * VIG_X / FRAME_W + dy * VIG_Y / FRAME_H;
        even_row = ~op.y[0];
        res.x     = op.x;
        res.y     = op.y;
        res.red   = shade_channel(rpix.red, op.noise_r, gain, even_row, vig);
        res.green = shade_channel(pix.green, op.noise_g, gain, even_row, vig);
        res.blue  = shade_channel(pix.blue, op.noise_b, gain, even_row, vig);
        res.alpha = pix.alpha;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // ---------------------------------------------------------------- driver

  always @(posedge clk_i) begin : driver
    pix_out_t res;
    if (!rst_ni) begin
      push <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) model_frac = cfg_data_i;
      if (push && !full) begin
        items_accepted++;
        if (filter_item(drv_op, res)) begin
          expected_pixels.push_back(res);
          emits_sent <= emits_sent + 1;
        end
      end
      if (!push || !full) begin
        if (op_q.size() != 0 && $urandom_range(99) >= send_idle_pct &&
            !(op_q[0].drain_first && (push || emits_sent != emits_taken))) begin
          drv_op <= op_q.pop_front();
          push   <= 1'b1;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  task automatic check_field(string name, int got, int want);
    if (got != want) begin
      err_cnt++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin : monitor
    pix_out_t want;
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_pixels.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected pixel, expected none, actual (%0d,%0d)",
                   $time, out_x_o, out_y_o);
        end else begin
          want = expected_pixels.pop_front();
          check_field("out_x", out_x_o, want.x);
          check_field("out_y", out_y_o, want.y);
          check_field("out_red", out_red_o, want.red);
          check_field("out_green", out_green_o, want.green);
          check_field("out_blue", out_blue_o, want.blue);
          check_field("out_alpha", out_alpha_o, want.alpha);
          emits_taken <= emits_taken + 1;
        end
      end
      pop <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin : watchdog
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d pixels outstanding",
               cycle_cnt, expected_pixels.size());
      $display("crt_scanline_noise_filter verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------- stimulus

  function automatic pix_op_t make_op(logic [1:0] kind, int col, int row);
    pix_op_t op;
    op.kind        = kind;
    op.x           = XW'(col);
    op.y           = YW'(row);
    op.red         = CHW'($urandom_range(255));
    op.green       = CHW'($urandom_range(255));
    op.blue        = CHW'($urandom_range(255));
    op.alpha       = CHW'($urandom_range(255));
    op.noise_r     = CHW'($urandom_range(255));
    op.noise_g     = CHW'($urandom_range(255));
    op.noise_b     = CHW'($urandom_range(255));
    op.dice        = DICE_W'($urandom_range(4095));
    op.red_shift   = SHFT_W'($urandom_range(3));
    op.drain_first = 1'b0;
    return op;
  endfunction

  function automatic void queue_op(pix_op_t op);
    op.drain_first = hold_next;
    hold_next = 1'b0;
    if (op.kind == KIND_LOAD && op.x < FRAME_W && op.y < FRAME_H)
      gen_written[op.y * FRAME_W + op.x] = 1'b1;
    if (op.kind == KIND_TICK) gen_roll = advance_roll(gen_roll, op.dice);
    op_q.push_back(op);
  endfunction

  function automatic void ensure_loaded(int col, int row);
    if (!gen_written[row * FRAME_W + col]) queue_op(make_op(KIND_LOAD, col, row));
  endfunction

  // An emit reads two store entries at the rolled row; load them first if needed.
  function automatic void queue_emit(pix_op_t op);
    int srow;
    op.kind = KIND_EMIT;
    if (op.x < FRAME_W && op.y < FRAME_H) begin
      srow = sample_row(gen_roll, gen_frac, op.y);
      ensure_loaded(op.x, srow);
      ensure_loaded(red_column(op.x, op.red_shift), srow);
    end
    queue_op(op);
  endfunction

  function automatic void queue_tick(int dice);
    pix_op_t op;
    op = make_op(KIND_TICK, $urandom_range(511), $urandom_range(255));
    op.dice = DICE_W'(dice);
    queue_op(op);
  endfunction

  function automatic void queue_directed();
    pix_op_t op;
    // white top-left corner with full noise: saturation, even row, widest vignette
    op = make_op(KIND_LOAD, 0, 0);
    op.red = 8'd255; op.green = 8'd255; op.blue = 8'd255; op.alpha = 8'd255;
    queue_op(op);
    op = make_op(KIND_EMIT, 0, 0);
    op.red_shift = 2'd0; op.noise_r = 8'd255; op.noise_g = 8'd255; op.noise_b = 8'd255;
    queue_emit(op);
    // black bottom-right corner, no noise, red column clamps at the edge
    op = make_op(KIND_LOAD, FRAME_W - 1, FRAME_H - 1);
    op.red = 8'd0; op.green = 8'd0; op.blue = 8'd0; op.alpha = 8'd0;
    queue_op(op);
    op = make_op(KIND_EMIT, FRAME_W - 1, FRAME_H - 1);
    op.red_shift = 2'd3; op.noise_r = 8'd0; op.noise_g = 8'd0; op.noise_b = 8'd0;
    queue_emit(op);
    op = make_op(KIND_EMIT, FRAME_W - 2, 1);
    op.red_shift = 2'd3;
    queue_emit(op);
    // positions off the frame and the unused kind
    queue_op(make_op(KIND_LOAD, 511, 255));
    queue_op(make_op(KIND_LOAD, FRAME_W, 0));
    queue_op(make_op(KIND_LOAD, 0, FRAME_H));
    queue_emit(make_op(KIND_EMIT, FRAME_W, 5));
    queue_emit(make_op(KIND_EMIT, 5, FRAME_H));
    queue_emit(make_op(KIND_EMIT, 511, 255));
    queue_op(make_op(KIND_NONE, 7, 7));
    // roll start threshold, then the noisy band at the bottom of the frame
    queue_tick(4095);
    queue_tick(ROLL_START_LIMIT);
    queue_tick(ROLL_START_LIMIT - 1);
    op = make_op(KIND_EMIT, 100, 215); op.dice = 12'd3;    queue_emit(op);
    op = make_op(KIND_EMIT, 101, 215); op.dice = 12'd14;   queue_emit(op);
    op = make_op(KIND_EMIT, 102, 200); op.dice = 12'd0;    queue_emit(op);
    op = make_op(KIND_EMIT, 103, 219); op.dice = 12'd4093; queue_emit(op);
    queue_tick(0);
    op = make_op(KIND_EMIT, 160, 239); op.dice = 12'd1;    queue_emit(op);
  endfunction

  // Queues about n items, counting the loads that emits pull in.
  function automatic void queue_random(int n);
    int      start_cnt, pick, tgt;
    pix_op_t op;
    start_cnt = op_q.size();
    while (op_q.size() - start_cnt < n) begin
      pick = $urandom_range(99);
      if (pick < 50) begin
        op = make_op(KIND_EMIT, $urandom_range(FRAME_W - 1), $urandom_range(FRAME_H - 1));
        // steer some emits into the bottom band while the frame rolls
        if (gen_roll.active && $urandom_range(3) == 0) begin
          tgt  = $urandom_range(FRAME_H - 1, FRAME_H - NOISE_ZONE + 1);
          op.y = YW'((tgt - roll_offset(gen_roll, gen_frac) + 2 * FRAME_H) % FRAME_H);
        end
        queue_emit(op);
      end else if (pick < 70) begin
        queue_op(make_op(KIND_LOAD, $urandom_range(FRAME_W - 1), $urandom_range(FRAME_H - 1)));
      end else if (pick < 82) begin
        queue_tick($urandom_range(1) ? $urandom_range(15) : $urandom_range(4095));
      end else if (pick < 94) begin
        if ($urandom_range(1))
          op = make_op(KIND_LOAD, $urandom_range(511, FRAME_W), $urandom_range(255));
        else
          op = make_op(KIND_LOAD, $urandom_range(511), $urandom_range(255, FRAME_H));
        if (pick < 88) queue_emit(op);
        else queue_op(op);
      end else begin
        queue_op(make_op(KIND_NONE, $urandom_range(511), $urandom_range(255)));
      end
    end
  endfunction

  task automatic wait_drain();
    while (op_q.size() != 0 || push || emits_sent != emits_taken) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_frac(logic [FRAC_W-1:0] frac);
    @(posedge clk_i);
    cfg_valid  <= 1'b1;
    cfg_data_i <= frac;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    gen_frac = frac;
    @(negedge clk_i);
  endtask

  task automatic run_phase(logic [FRAC_W-1:0] frac, int send_idle, int recv_idle,
                           int n, bit pause_mid);
    send_idle_pct = send_idle;
    recv_idle_pct = recv_idle;
    write_frac(frac);
    queue_random(n / 2);
    hold_next = pause_mid;
    queue_random(n - n / 2);
    wait_drain();
  endtask

  initial begin : stimulus
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    send_idle_pct = 22;
    recv_idle_pct = 70;
    @(negedge clk_i);
    queue_directed();
    wait_drain();

    run_phase(9'd0,   22, 70, 84, 1'b0);
    run_phase(9'd511, 22, 70, 84, 1'b0);
    run_phase(9'd128, 70, 22, 84, 1'b1);
    run_phase(FRAC_W'($urandom_range(511)), 70, 22, 84, 1'b0);
    run_phase(9'd256, 0,  0,  84, 1'b0);

    if (expected_pixels.size() != 0) err_cnt++;
    $display("Checked %0d filtered pixels over %0d accepted items: %0d in the noisy band,",
             emits_taken, items_accepted, hi_gain_cnt);
    $display("%0d ticks with the roll active, weights 0/128/256/511 plus one random.",
             roll_tick_cnt);
    if (err_cnt == 0)
      $display("crt_scanline_noise_filter verification clean");
    else
      $display("crt_scanline_noise_filter verification failed");
    $finish;
  end

endmodule
